>>> rtl/tpt_pkg.sv
// tpt_pkg: field widths, operation codes and status codes of the task
// priority table. No dependencies.
`timescale 1ns / 1ps

package tpt_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_IN_W = 16;
    localparam int OWNER_W  = 16;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

endpackage

>>> rtl/tpt_ram.sv
// tpt_ram: single-clock RAM, one write port and one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module tpt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 65
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/task_priority_table.sv
// task_priority_table: top level of the task table with add, edit, remove
// and take-top operations. Depends on tpt_pkg and tpt_ram.
`timescale 1ns / 1ps

// Each item on start (taken when busy is low) is one operation on a table of
// TASK_SLOTS task entries held in a single RAM. The block scans all entries,
// one entry per cycle through its one read port, tracking the entry matching
// the key, the lowest free entry and the top-priority entry, then does at
// most one write and posts the result. An item passes from accept to the
// next possible accept through the scan reads, the handling of the last read
// data, a wait for the read pipe to empty, the write, and the idle cycle that
// carries done. done pulses high for one cycle with owner_out and status, in
// the same cycle that busy drops. The receiver cannot stall, so the result
// must be captured on that cycle. After reset the block stays busy while it
// clears the valid bit of every entry. Keys are kept to their low KEY_BITS
// bits.

module task_priority_table #(
    parameter int TASK_SLOTS = 64,
    parameter int KEY_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tpt_pkg::MODE_W-1:0]     mode,
    input  logic [tpt_pkg::KEY_IN_W-1:0]   task_key,
    input  logic [tpt_pkg::OWNER_W-1:0]    owner,
    input  logic [tpt_pkg::PRIO_W-1:0]     prio,
    output logic                           done,
    output logic [tpt_pkg::OWNER_W-1:0]    owner_out,
    output logic [tpt_pkg::STATUS_W-1:0]   status
);

    import tpt_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = IW + 1;
    // entry word: {valid, key, owner, prio}
    localparam int EW      = 1 + KEY_BITS + OWNER_W + PRIO_W;
    localparam int PRIO_LO = 0;
    localparam int OWN_LO  = PRIO_W;
    localparam int KEY_LO  = PRIO_W + OWNER_W;
    localparam int VAL_BIT = EW - 1;
    localparam logic [CW-1:0] LAST = CW'(TASK_SLOTS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic                chk_reg;       // read data valid this cycle
    logic [IW-1:0]       chk_idx_reg;   // entry the read data belongs to

    // latched item
    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [PRIO_W-1:0]   prio_reg;

    // scan trackers
    logic                hit_reg, free_reg, best_reg;
    logic [IW-1:0]       hit_idx_reg, free_idx_reg, best_idx_reg;
    logic [OWNER_W-1:0]  hit_owner_reg, best_owner_reg;
    logic [PRIO_W-1:0]   best_prio_reg;
    logic [KEY_BITS-1:0] best_key_reg;

    // result
    logic                done_reg;
    logic [OWNER_W-1:0]  owner_out_reg;
    logic [STATUS_W-1:0] status_reg;

    // RAM ports
    logic                rd_en, wr_en;
    logic [IW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data, rd_data;

    logic [31:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic                accept;

    logic                e_valid;
    logic [KEY_BITS-1:0] e_key;
    logic [OWNER_W-1:0]  e_owner;
    logic [PRIO_W-1:0]   e_prio;
    logic                e_better;

    assign key_wide = {{(32 - KEY_IN_W){1'b0}}, task_key};
    assign key_in   = key_wide[KEY_BITS-1:0];
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;

    assign e_valid = rd_data[VAL_BIT];
    assign e_key   = rd_data[KEY_LO +: KEY_BITS];
    assign e_owner = rd_data[OWN_LO +: OWNER_W];
    assign e_prio  = rd_data[PRIO_LO +: PRIO_W];
    assign e_better = !best_reg || (e_prio > best_prio_reg) ||
                      ((e_prio == best_prio_reg) && (e_key > best_key_reg));

    tpt_ram #(
        .DEPTH (1 << IW),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        rd_en      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                addr_next = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg != LAST)
                begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (!chk_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            chk_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            chk_reg   <= rd_en;
            done_reg  <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= addr_reg[IW-1:0];
    end

    // item latch and scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            best_reg <= 1'b0;
        end
        else if (accept)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            best_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN && chk_reg)
        begin
            if (e_valid && (e_key == key_reg) && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!e_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (e_valid && e_better)
            begin
                best_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key_in;
            owner_reg <= owner;
            prio_reg  <= prio;
        end
        else if (state_reg == ST_SCAN && chk_reg)
        begin
            if (e_valid && (e_key == key_reg) && !hit_reg)
            begin
                hit_idx_reg   <= chk_idx_reg;
                hit_owner_reg <= e_owner;
            end
            if (!e_valid && !free_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
            if (e_valid && e_better)
            begin
                best_idx_reg   <= chk_idx_reg;
                best_owner_reg <= e_owner;
                best_prio_reg  <= e_prio;
                best_key_reg   <= e_key;
            end
        end
    end

    // the one write of an item, or the clearing pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg[IW-1:0];
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_DONE)
        begin
            case (mode_reg)
                MODE_ADD:
                begin
                    wr_en   = hit_reg || free_reg;
                    wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;
                    wr_data = {1'b1, key_reg, owner_reg, prio_reg};
                end
                MODE_EDIT:
                begin
                    wr_en   = hit_reg;
                    wr_addr = hit_idx_reg;
                    wr_data = {1'b1, key_reg, hit_owner_reg, prio_reg};
                end
                MODE_REMOVE:
                begin
                    wr_en   = hit_reg;
                    wr_addr = hit_idx_reg;
                end
                MODE_TOP:
                begin
                    wr_en   = best_reg;
                    wr_addr = best_idx_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            case (mode_reg)
                MODE_ADD:
                begin
                    owner_out_reg <= '0;
                    status_reg    <= (!hit_reg && !free_reg) ? STATUS_FULL : STATUS_OK;
                end
                MODE_EDIT, MODE_REMOVE:
                begin
                    owner_out_reg <= '0;
                    status_reg    <= hit_reg ? STATUS_OK : STATUS_ABSENT;
                end
                MODE_TOP:
                begin
                    owner_out_reg <= best_reg ? best_owner_reg : '0;
                    status_reg    <= best_reg ? STATUS_OK : STATUS_ABSENT;
                end
                default:
                begin
                    owner_out_reg <= '0;
                    status_reg    <= STATUS_OK;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign owner_out = owner_out_reg;
    assign status    = status_reg;

    // checks
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> done)
        else $error("result strobe missing after finish");

    a_done_only_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_DONE))
        else $error("result strobe without finished item");

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && (state_reg == ST_SCAN)))
        else $error("RAM write during scan");

    a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (mode_reg == MODE_ADD))
        else $error("full status on non-add item");

    a_owner_only_on_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (owner_out != '0)) |-> (mode_reg == MODE_TOP))
        else $error("owner returned on non take-top item");

endmodule
